FILE: hdl/bfmh_pkg.sv
package bfmh_pkg;

  localparam int FILTER_WORDS = 16384;
  localparam int MAX_PROBES   = 5;

  localparam int ADDR_W = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
  localparam int BIT_W  = ADDR_W + 6;
  localparam int M_W    = BIT_W + 1;
  localparam int PC_W   = $clog2(MAX_PROBES + 1);

  localparam logic [M_W-1:0] MAX_BITS = M_W'(FILTER_WORDS * 64);

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_R1 = 64'h0000000052dce729;
  localparam logic [63:0] MM_R2 = 64'h0000000038495ab5;
  localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic REG_FILTER_BITS = 1'b0;
  localparam logic REG_PROBE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] h1;
    logic [63:0] h2;
  } cmd_t;

  typedef enum logic [3:0] {
    F_IDLE, F_A1, F_A2, F_AUPD, F_B1, F_B2, F_BUPD,
    F_FIN0, F_M1, F_M2, F_FIN1, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_CLR, B_DIV, B_PRD, B_PCHK, B_RES
  } back_state_t;

endpackage

FILE: hdl/bloom_filter_murmur3_double_hash_unit.sv
// Bloom filter keyed by a streamed MurmurHash3 x64_128 hash (seed zero).
// Input channel: one key word per handshake (word_valid / word_stall). A key is a
// run of 64-bit little-endian words; last_word marks the final one, whose op
// (insert or query) applies to the whole key. op clear empties the filter.
// Output channel: one word (hit, insert_total) per finished key and per clear,
// on result_valid / result_stall, from an output register.
// Front end: hashes words with one shared 32x32 multiplier, building each
// 64-bit product from 32x32 partials. An unpaired word is only held, a word
// that completes a 16-byte block is mixed into both hash halves, and the key
// finish (fmix on both halves) follows the mixing of the last word.
// Back end: per key, a pop, a bit-serial remainder of both halves by filter_bits
// (clamped to 1 .. FILTER_WORDS*64), then per probe a read and (on insert) a
// modify/write of the 64-bit store word, and a result; overlapped with the front
// end through a two-entry command queue. A clear sweeps the store in the back
// end, one store word per cycle.
// Reset: synchronous. After reset the store is swept to zero; during the sweep
// word_stall stays high, and configuration writes still land.
// A stalled result holds the back end; the front end keeps hashing until the
// queue fills, then raises word_stall.
module bloom_filter_murmur3_double_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        word_valid,
  output logic        word_stall,
  input  logic [1:0]  op,
  input  logic [63:0] key_word,
  input  logic [3:0]  word_bytes,
  input  logic        last_word,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        hit,
  output logic [31:0] insert_total
);

  logic [20:0]    filter_bits;
  logic [2:0]     probe_count;
  logic           push, q_full, q_valid, pop, init_busy, front_stall;
  bfmh_pkg::cmd_t push_cmd, q_cmd;

  assign pready = 1'b1;

  // register select by word address; bit 2 picks the register
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bits <= 21'd1048576;
      probe_count <= 3'd3;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        bfmh_pkg::REG_FILTER_BITS: filter_bits <= pwdata[20:0];
        bfmh_pkg::REG_PROBE_COUNT: probe_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bfmh_pkg::REG_FILTER_BITS: prdata = {11'd0, filter_bits};
      bfmh_pkg::REG_PROBE_COUNT: prdata = {29'd0, probe_count};
      default:                   prdata = 32'd0;
    endcase
  end

  // hold the input side while the power-up sweep runs
  assign word_stall = front_stall;

  bfmh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (init_busy),
    .word_valid (word_valid),
    .word_stall (front_stall),
    .op         (op),
    .key_word   (key_word),
    .word_bytes (word_bytes),
    .last_word  (last_word),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  bfmh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  bfmh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .filter_bits  (filter_bits),
    .probe_count  (probe_count),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .insert_total (insert_total)
  );

endmodule

FILE: hdl/bfmh_front.sv
module bfmh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               hold,
  input  logic               word_valid,
  output logic               word_stall,
  input  logic [1:0]         op,
  input  logic [63:0]        key_word,
  input  logic [3:0]         word_bytes,
  input  logic               last_word,
  output logic               push,
  output bfmh_pkg::cmd_t     push_cmd,
  input  logic               q_full
);

  bfmh_pkg::front_state_t state, state_next;
  logic [1:0]  mph;
  logic [63:0] acc, w, h1, h2, held, hi_w;
  logic        held_valid, do_b, fold, fin, fx;
  logic [31:0] klen;
  logic [1:0]  kop;

  logic        accept, mul_st, ph_end;
  logic [3:0]  nb;
  logic [63:0] wm, kc, mul_p, pf, t_a, t_b, fa, fb, ft, pmix;
  logic [31:0] mx, my;

  assign accept = word_valid && (state == bfmh_pkg::F_IDLE) && !q_full && !hold;
  assign word_stall = !((state == bfmh_pkg::F_IDLE) && !q_full && !hold);

  assign nb = (word_bytes > 4'd8) ? 4'd8 : word_bytes;
  assign wm = (nb == 4'd8) ? key_word :
              (key_word & ((64'd1 << {nb[2:0], 3'b000}) - 64'd1));

  assign mul_st = (state == bfmh_pkg::F_A1) || (state == bfmh_pkg::F_A2) ||
                  (state == bfmh_pkg::F_B1) || (state == bfmh_pkg::F_B2) ||
                  (state == bfmh_pkg::F_M1) || (state == bfmh_pkg::F_M2);
  assign ph_end = mul_st && (mph == 2'd2);

  always_comb begin
    unique case (state)
      bfmh_pkg::F_A1, bfmh_pkg::F_B2: kc = bfmh_pkg::MM_C1;
      bfmh_pkg::F_A2, bfmh_pkg::F_B1: kc = bfmh_pkg::MM_C2;
      bfmh_pkg::F_M1:                 kc = bfmh_pkg::MM_F1;
      default:                        kc = bfmh_pkg::MM_F2;
    endcase
    unique case (mph)
      2'd0: begin
        mx = w[31:0];
        my = kc[31:0];
      end
      2'd1: begin
        mx = w[31:0];
        my = kc[63:32];
      end
      default: begin
        mx = w[63:32];
        my = kc[31:0];
      end
    endcase
  end

  // low 64 bits of the product, one 32x32 partial per cycle
  assign mul_p = mx * my;
  assign pf    = acc + {mul_p[31:0], 32'b0};
  assign pmix  = pf ^ (pf >> 33);

  assign t_a = ({h1[36:0], h1[63:37]}) + h2;
  assign t_b = ({h2[32:0], h2[63:33]}) + h1;
  assign fa  = h1 ^ {32'b0, klen};
  assign fb  = h2 ^ {32'b0, klen};
  assign ft  = fa + fb;

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_cmd   = '{op: kop, h1: h1, h2: h2};
    unique case (state)
      bfmh_pkg::F_IDLE: begin
        if (accept) begin
          if (op == bfmh_pkg::OP_CLEAR) begin
            push     = 1'b1;
            push_cmd = '{op: bfmh_pkg::OP_CLEAR, h1: 64'd0, h2: 64'd0};
          end else if (op != bfmh_pkg::OP_NONE) begin
            if (!last_word) begin
              if (held_valid) state_next = bfmh_pkg::F_A1;
            end else if (held_valid || (nb != 4'd0)) begin
              state_next = bfmh_pkg::F_A1;
            end else begin
              state_next = bfmh_pkg::F_FIN0;
            end
          end
        end
      end
      bfmh_pkg::F_A1: if (ph_end) state_next = bfmh_pkg::F_A2;
      bfmh_pkg::F_A2: begin
        if (ph_end) begin
          priority if (fold) state_next = bfmh_pkg::F_AUPD;
          else if (do_b)     state_next = bfmh_pkg::F_B1;
          else if (fin)      state_next = bfmh_pkg::F_FIN0;
          else               state_next = bfmh_pkg::F_IDLE;
        end
      end
      bfmh_pkg::F_AUPD: state_next = bfmh_pkg::F_B1;
      bfmh_pkg::F_B1: if (ph_end) state_next = bfmh_pkg::F_B2;
      bfmh_pkg::F_B2: begin
        if (ph_end) begin
          priority if (fold) state_next = bfmh_pkg::F_BUPD;
          else if (fin)      state_next = bfmh_pkg::F_FIN0;
          else               state_next = bfmh_pkg::F_IDLE;
        end
      end
      bfmh_pkg::F_BUPD: state_next = fin ? bfmh_pkg::F_FIN0 : bfmh_pkg::F_IDLE;
      bfmh_pkg::F_FIN0: state_next = bfmh_pkg::F_M1;
      bfmh_pkg::F_M1: if (ph_end) state_next = bfmh_pkg::F_M2;
      bfmh_pkg::F_M2: if (ph_end) state_next = fx ? bfmh_pkg::F_FIN1 : bfmh_pkg::F_M1;
      bfmh_pkg::F_FIN1: state_next = bfmh_pkg::F_PUSH;
      bfmh_pkg::F_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = bfmh_pkg::F_IDLE;
        end
      end
      default: state_next = bfmh_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfmh_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mph        <= 2'd0;
      h1         <= 64'd0;
      h2         <= 64'd0;
      held_valid <= 1'b0;
      klen       <= 32'd0;
    end else begin
      if (mul_st) begin
        mph <= ph_end ? 2'd0 : mph + 2'd1;
        if (mph == 2'd0) acc <= mul_p;
        else if (mph == 2'd1) acc <= pf;
      end
      unique case (state)
        bfmh_pkg::F_IDLE: begin
          if (accept) begin
            if (op == bfmh_pkg::OP_CLEAR) begin
              h1         <= 64'd0;
              h2         <= 64'd0;
              held_valid <= 1'b0;
              klen       <= 32'd0;
            end else if (op != bfmh_pkg::OP_NONE) begin
              if (!last_word) begin
                klen <= klen + 32'd8;
                fin  <= 1'b0;
                if (held_valid) begin
                  w          <= held;
                  hi_w       <= key_word;
                  fold       <= 1'b1;
                  do_b       <= 1'b1;
                  held_valid <= 1'b0;
                end else begin
                  held       <= key_word;
                  held_valid <= 1'b1;
                end
              end else begin
                kop        <= op;
                klen       <= klen + 32'(nb);
                fin        <= 1'b1;
                held_valid <= 1'b0;
                if (held_valid) begin
                  w    <= held;
                  hi_w <= wm;
                  do_b <= (nb != 4'd0);
                  fold <= (nb == 4'd8);
                end else begin
                  w    <= wm;
                  do_b <= 1'b0;
                  fold <= 1'b0;
                end
              end
            end
          end
        end
        bfmh_pkg::F_A1: if (ph_end) w <= {pf[32:0], pf[63:33]};
        bfmh_pkg::F_A2: begin
          if (ph_end) begin
            h1 <= h1 ^ pf;
            w  <= hi_w;
          end
        end
        bfmh_pkg::F_AUPD: h1 <= t_a + (t_a << 2) + bfmh_pkg::MM_R1;
        bfmh_pkg::F_B1: if (ph_end) w <= {pf[30:0], pf[63:31]};
        bfmh_pkg::F_B2: if (ph_end) h2 <= h2 ^ pf;
        bfmh_pkg::F_BUPD: h2 <= t_b + (t_b << 2) + bfmh_pkg::MM_R2;
        bfmh_pkg::F_FIN0: begin
          h1 <= ft;
          h2 <= fb + ft;
          w  <= ft ^ (ft >> 33);
          fx <= 1'b0;
        end
        bfmh_pkg::F_M1: if (ph_end) w <= pmix;
        bfmh_pkg::F_M2: begin
          if (ph_end) begin
            if (!fx) begin
              h1 <= pmix;
              fx <= 1'b1;
              w  <= h2 ^ (h2 >> 33);
            end else begin
              h2 <= pmix;
            end
          end
        end
        bfmh_pkg::F_FIN1: begin
          h1 <= h1 + h2;
          h2 <= h2 + (h1 + h2);
        end
        bfmh_pkg::F_PUSH: begin
          if (!q_full) begin
            h1   <= 64'd0;
            h2   <= 64'd0;
            klen <= 32'd0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/bfmh_queue.sv
module bfmh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bfmh_pkg::cmd_t push_cmd,
  output logic           q_full,
  output logic           q_valid,
  output bfmh_pkg::cmd_t q_cmd,
  input  logic           pop
);

  bfmh_pkg::cmd_t ent [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hdl/bfmh_back.sv
module bfmh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [20:0]    filter_bits,
  input  logic [2:0]     probe_count,
  input  logic           q_valid,
  input  bfmh_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           init_busy,
  output logic           result_valid,
  input  logic           result_stall,
  output logic           hit,
  output logic [31:0]    insert_total
);

  localparam int AW = bfmh_pkg::ADDR_W;
  localparam int BW = bfmh_pkg::BIT_W;
  localparam int MW = bfmh_pkg::M_W;
  localparam int PW = bfmh_pkg::PC_W;

  bfmh_pkg::back_state_t state, state_next;
  logic [63:0]   store [bfmh_pkg::FILTER_WORDS];
  logic [63:0]   rdata, wdata;
  logic [AW-1:0] caddr, waddr;
  logic          we, init, report, all_set;
  logic [1:0]    cop;
  logic [63:0]   d1, d2;
  logic [MW-1:0] m, rem1, rem2, rem1_next, rem2_next, m_c;
  logic [MW:0]   r1, r2, nsum;
  logic [5:0]    dcnt;
  logic [BW-1:0] idx, stride, idx_next;
  logic [PW-1:0] k, k_c, pcnt;
  logic [31:0]   total;
  logic          out_free, bit_set;

  assign init_busy = init;
  assign out_free  = !result_valid || !result_stall;

  always_comb begin
    priority if (filter_bits == 21'd0)                m_c = MW'(1);
    else if (32'(filter_bits) > 32'(bfmh_pkg::MAX_BITS)) m_c = bfmh_pkg::MAX_BITS;
    else                                               m_c = MW'(filter_bits);
    priority if (probe_count == 3'd0)                  k_c = PW'(1);
    else if (32'(probe_count) > 32'(bfmh_pkg::MAX_PROBES)) k_c = PW'(bfmh_pkg::MAX_PROBES);
    else                                               k_c = PW'(probe_count);
  end

  // one restoring remainder step per cycle for each hash half
  assign r1 = {rem1, d1[63]};
  assign r2 = {rem2, d2[63]};
  assign rem1_next = (r1 >= {1'b0, m}) ? MW'(r1 - {1'b0, m}) : MW'(r1);
  assign rem2_next = (r2 >= {1'b0, m}) ? MW'(r2 - {1'b0, m}) : MW'(r2);

  assign nsum     = (MW+1)'(idx) + (MW+1)'(stride);
  assign idx_next = (nsum >= (MW+1)'(m)) ? BW'(nsum - (MW+1)'(m)) : BW'(nsum);
  assign bit_set  = rdata[idx[5:0]];

  always_comb begin
    state_next = state;
    pop   = 1'b0;
    we    = 1'b0;
    waddr = caddr;
    wdata = 64'd0;
    unique case (state)
      bfmh_pkg::B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = (q_cmd.op == bfmh_pkg::OP_CLEAR) ? bfmh_pkg::B_CLR : bfmh_pkg::B_DIV;
        end
      end
      bfmh_pkg::B_CLR: begin
        we = 1'b1;
        if (caddr == AW'(bfmh_pkg::FILTER_WORDS - 1)) begin
          state_next = report ? bfmh_pkg::B_RES : bfmh_pkg::B_IDLE;
        end
      end
      bfmh_pkg::B_DIV: if (dcnt == 6'd63) state_next = bfmh_pkg::B_PRD;
      bfmh_pkg::B_PRD: state_next = bfmh_pkg::B_PCHK;
      bfmh_pkg::B_PCHK: begin
        waddr = AW'(idx[BW-1:6]);
        wdata = rdata | (64'd1 << idx[5:0]);
        we    = (cop == bfmh_pkg::OP_INSERT);
        state_next = (pcnt == k - PW'(1)) ? bfmh_pkg::B_RES : bfmh_pkg::B_PRD;
      end
      bfmh_pkg::B_RES: if (out_free) state_next = bfmh_pkg::B_IDLE;
      default: state_next = bfmh_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    rdata <= store[AW'(idx[BW-1:6])];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfmh_pkg::B_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      caddr        <= '0;
      init         <= 1'b1;
      report       <= 1'b0;
      total        <= 32'd0;
      result_valid <= 1'b0;
    end else begin
      if ((state == bfmh_pkg::B_RES) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        bfmh_pkg::B_IDLE: begin
          if (q_valid) begin
            cop  <= q_cmd.op;
            d1   <= q_cmd.h1;
            d2   <= q_cmd.h2;
            m    <= m_c;
            k    <= k_c;
            rem1 <= '0;
            rem2 <= '0;
            dcnt <= 6'd0;
            if (q_cmd.op == bfmh_pkg::OP_CLEAR) begin
              caddr  <= '0;
              report <= 1'b1;
              total  <= 32'd0;
            end
          end
        end
        bfmh_pkg::B_CLR: begin
          caddr <= caddr + AW'(1);
          if (caddr == AW'(bfmh_pkg::FILTER_WORDS - 1)) init <= 1'b0;
        end
        bfmh_pkg::B_DIV: begin
          rem1 <= rem1_next;
          rem2 <= rem2_next;
          d1   <= d1 << 1;
          d2   <= d2 << 1;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            idx     <= BW'(rem1_next);
            stride  <= BW'(rem2_next);
            pcnt    <= '0;
            all_set <= 1'b1;
          end
        end
        bfmh_pkg::B_PRD: ;
        bfmh_pkg::B_PCHK: begin
          if (!bit_set) all_set <= 1'b0;
          idx  <= idx_next;
          pcnt <= pcnt + PW'(1);
          if ((pcnt == k - PW'(1)) && (cop == bfmh_pkg::OP_INSERT) && (total != 32'hFFFFFFFF)) begin
            total <= total + 32'd1;
          end
        end
        bfmh_pkg::B_RES: begin
          if (out_free) begin
            hit          <= (cop == bfmh_pkg::OP_QUERY) && all_set;
            insert_total <= total;
            report       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == bfmh_pkg::B_PCHK) |-> (MW'(idx) < m))
    else $error("probe index at or above filter size");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == bfmh_pkg::B_DIV) |-> ((rem1 < m) && (rem2 < m)))
    else $error("partial remainder at or above filter size");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue popped while empty");
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    init |-> !result_valid)
    else $error("result shown during power-up clear");
`endif

endmodule
